### rtl/core/quaternion_vector_rotate_top_macros.svh
// Assertion macros used by the quaternion rotation RTL.
`ifndef QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_MACROS_SVH

// Check a same-cycle implication.
`define QVR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check an implication in the following cycle.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/qvr_pkg.sv
// Package: widths, constants and shared types of the quaternion rotation pipeline.
package qvr_pkg;

	// Field widths
	localparam int QW = 16;          // quaternion component, Q1.14
	localparam int VW = 24;          // vector component
	localparam int PW = 2 * QW;      // pairwise product, Q3.28
	localparam int HW = PW + 1;      // half matrix entry, scale 2^28
	localparam int MW = VW + HW;     // vector times half entry
	localparam int AW = MW + 2;      // sum of three such products
	localparam int FRAC_H = 2 * (QW - 2) - 1;  // fraction bits of the half-matrix sum
	localparam int RW = AW - FRAC_H; // rounded sum before clamping

	// One half in the product scale, used for the diagonal entries
	localparam logic signed [HW-1:0] H_ONE = HW'(1) << FRAC_H;
	// Rounding offset applied before dropping the fraction
	localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC_H - 1);

	localparam logic signed [VW-1:0] VEC_MAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VEC_MIN = {1'b1, {(VW-1){1'b0}}};

	// Half rotation matrix together with the vector it applies to
	typedef struct packed {
		logic signed [HW-1:0] h00;
		logic signed [HW-1:0] h01;
		logic signed [HW-1:0] h02;
		logic signed [HW-1:0] h10;
		logic signed [HW-1:0] h11;
		logic signed [HW-1:0] h12;
		logic signed [HW-1:0] h20;
		logic signed [HW-1:0] h21;
		logic signed [HW-1:0] h22;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic signed [VW-1:0] vz;
	} qvr_mat_t;

	// Exact product of two quaternion components
	function automatic logic signed [PW-1:0] mul_q(
		input logic signed [QW-1:0] a,
		input logic signed [QW-1:0] b
	);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		return p;
	endfunction

	// Exact product of a vector component and a half matrix entry
	function automatic logic signed [MW-1:0] mul_vh(
		input logic signed [VW-1:0] v,
		input logic signed [HW-1:0] h
	);
		logic signed [MW-1:0] p;
		p = MW'(v) * MW'(h);
		return p;
	endfunction

endpackage

### rtl/core/qvr_in_if.sv
// Interface: input channel carrying quaternion and vector.
interface qvr_in_if;
	logic valid;
	logic ready;
	logic signed [qvr_pkg::QW-1:0] quat_w;
	logic signed [qvr_pkg::QW-1:0] quat_x;
	logic signed [qvr_pkg::QW-1:0] quat_y;
	logic signed [qvr_pkg::QW-1:0] quat_z;
	logic signed [qvr_pkg::VW-1:0] vec_x;
	logic signed [qvr_pkg::VW-1:0] vec_y;
	logic signed [qvr_pkg::VW-1:0] vec_z;

	modport source (
		output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		input ready
	);
	modport sink (
		input valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
		output ready
	);
endinterface

### rtl/core/qvr_out_if.sv
// Interface: output channel carrying the rotated vector and overflow flag.
interface qvr_out_if;
	logic valid;
	logic ready;
	logic signed [qvr_pkg::VW-1:0] out_x;
	logic signed [qvr_pkg::VW-1:0] out_y;
	logic signed [qvr_pkg::VW-1:0] out_z;
	logic overflow;

	modport source (
		output valid, out_x, out_y, out_z, overflow,
		input ready
	);
	modport sink (
		input valid, out_x, out_y, out_z, overflow,
		output ready
	);
endinterface

### rtl/core/qvr_front.sv
// Module: pairwise quaternion products and half rotation matrix (stages 1 and 2).
module qvr_front (
	input  logic             clk,
	input  logic             arst_n,
	qvr_in_if.sink           sample,
	output logic             mat_valid,
	input  logic             mat_ready,
	output qvr_pkg::qvr_mat_t mat
);

	typedef struct packed {
		logic signed [qvr_pkg::PW-1:0] xx;
		logic signed [qvr_pkg::PW-1:0] yy;
		logic signed [qvr_pkg::PW-1:0] zz;
		logic signed [qvr_pkg::PW-1:0] ww;
		logic signed [qvr_pkg::PW-1:0] xy;
		logic signed [qvr_pkg::PW-1:0] xz;
		logic signed [qvr_pkg::PW-1:0] yz;
		logic signed [qvr_pkg::PW-1:0] wx;
		logic signed [qvr_pkg::PW-1:0] wy;
		logic signed [qvr_pkg::PW-1:0] wz;
		logic signed [qvr_pkg::VW-1:0] vx;
		logic signed [qvr_pkg::VW-1:0] vy;
		logic signed [qvr_pkg::VW-1:0] vz;
	} qvr_prod_t;

	logic              valid_s1;
	logic              valid_s2;
	logic              free_s2;
	qvr_prod_t         prod_s1;
	qvr_pkg::qvr_mat_t mat_s2;

	// Each stage takes a transaction when empty or when its content moves on
	assign free_s2      = !valid_s2 || mat_ready;
	assign sample.ready = !valid_s1 || free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Stage 1: form the ten pairwise products
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			prod_s1.xx <= qvr_pkg::mul_q(sample.quat_x, sample.quat_x);
			prod_s1.yy <= qvr_pkg::mul_q(sample.quat_y, sample.quat_y);
			prod_s1.zz <= qvr_pkg::mul_q(sample.quat_z, sample.quat_z);
			prod_s1.ww <= qvr_pkg::mul_q(sample.quat_w, sample.quat_w);
			prod_s1.xy <= qvr_pkg::mul_q(sample.quat_x, sample.quat_y);
			prod_s1.xz <= qvr_pkg::mul_q(sample.quat_x, sample.quat_z);
			prod_s1.yz <= qvr_pkg::mul_q(sample.quat_y, sample.quat_z);
			prod_s1.wx <= qvr_pkg::mul_q(sample.quat_w, sample.quat_x);
			prod_s1.wy <= qvr_pkg::mul_q(sample.quat_w, sample.quat_y);
			prod_s1.wz <= qvr_pkg::mul_q(sample.quat_w, sample.quat_z);
			prod_s1.vx <= sample.vec_x;
			prod_s1.vy <= sample.vec_y;
			prod_s1.vz <= sample.vec_z;
		end
	end

	// Stage 2: combine products into half matrix entries (diagonal less one half)
	always_ff @(posedge clk) begin
		if (valid_s1 && free_s2) begin
			mat_s2.h00 <= qvr_pkg::HW'(prod_s1.xx) + qvr_pkg::HW'(prod_s1.ww) - qvr_pkg::H_ONE;
			mat_s2.h01 <= qvr_pkg::HW'(prod_s1.xy) - qvr_pkg::HW'(prod_s1.wz);
			mat_s2.h02 <= qvr_pkg::HW'(prod_s1.wy) + qvr_pkg::HW'(prod_s1.xz);
			mat_s2.h10 <= qvr_pkg::HW'(prod_s1.xy) + qvr_pkg::HW'(prod_s1.wz);
			mat_s2.h11 <= qvr_pkg::HW'(prod_s1.yy) + qvr_pkg::HW'(prod_s1.ww) - qvr_pkg::H_ONE;
			mat_s2.h12 <= qvr_pkg::HW'(prod_s1.yz) - qvr_pkg::HW'(prod_s1.wx);
			mat_s2.h20 <= qvr_pkg::HW'(prod_s1.xz) - qvr_pkg::HW'(prod_s1.wy);
			mat_s2.h21 <= qvr_pkg::HW'(prod_s1.wx) + qvr_pkg::HW'(prod_s1.yz);
			mat_s2.h22 <= qvr_pkg::HW'(prod_s1.zz) + qvr_pkg::HW'(prod_s1.ww) - qvr_pkg::H_ONE;
			mat_s2.vx  <= prod_s1.vx;
			mat_s2.vy  <= prod_s1.vy;
			mat_s2.vz  <= prod_s1.vz;
		end
	end

	assign mat_valid = valid_s2;
	assign mat       = mat_s2;

endmodule

### rtl/core/qvr_mac.sv
// Module: matrix-vector multiply, rounding and saturation (stages 3 to 5).
`include "quaternion_vector_rotate_top_macros.svh"

module qvr_mac (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              mat_valid,
	output logic              mat_ready,
	input  qvr_pkg::qvr_mat_t mat,
	qvr_out_if.source         result
);

	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic free_s4;
	logic free_s5;

	logic signed [qvr_pkg::MW-1:0] p00_s3, p01_s3, p02_s3;
	logic signed [qvr_pkg::MW-1:0] p10_s3, p11_s3, p12_s3;
	logic signed [qvr_pkg::MW-1:0] p20_s3, p21_s3, p22_s3;

	logic signed [qvr_pkg::AW-1:0] sum_x, sum_y, sum_z;
	logic signed [qvr_pkg::RW-1:0] rx_s4, ry_s4, rz_s4;

	logic signed [qvr_pkg::VW-1:0] cx, cy, cz;
	logic                          ox, oy, oz;
	logic signed [qvr_pkg::VW-1:0] x_s5, y_s5, z_s5;
	logic                          ovf_s5;

	// Clamp a rounded sum to the vector range; the top bit flags saturation
	function automatic logic [qvr_pkg::VW:0] clamp(input logic signed [qvr_pkg::RW-1:0] r);
		logic [qvr_pkg::VW:0] o;
		if (r > qvr_pkg::RW'(qvr_pkg::VEC_MAX)) begin
			o = {1'b1, qvr_pkg::VEC_MAX};
		end else if (r < qvr_pkg::RW'(qvr_pkg::VEC_MIN)) begin
			o = {1'b1, qvr_pkg::VEC_MIN};
		end else begin
			o = {1'b0, r[qvr_pkg::VW-1:0]};
		end
		return o;
	endfunction

	// Advance a stage when it is empty or its content moves on
	assign free_s5   = !valid_s5 || result.ready;
	assign free_s4   = !valid_s4 || free_s5;
	assign mat_ready = !valid_s3 || free_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (mat_ready) begin
				valid_s3 <= mat_valid;
			end
			if (free_s4) begin
				valid_s4 <= valid_s3;
			end
			if (free_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage 3: nine vector-by-entry products
	always_ff @(posedge clk) begin
		if (mat_valid && mat_ready) begin
			p00_s3 <= qvr_pkg::mul_vh(mat.vx, mat.h00);
			p01_s3 <= qvr_pkg::mul_vh(mat.vy, mat.h01);
			p02_s3 <= qvr_pkg::mul_vh(mat.vz, mat.h02);
			p10_s3 <= qvr_pkg::mul_vh(mat.vx, mat.h10);
			p11_s3 <= qvr_pkg::mul_vh(mat.vy, mat.h11);
			p12_s3 <= qvr_pkg::mul_vh(mat.vz, mat.h12);
			p20_s3 <= qvr_pkg::mul_vh(mat.vx, mat.h20);
			p21_s3 <= qvr_pkg::mul_vh(mat.vy, mat.h21);
			p22_s3 <= qvr_pkg::mul_vh(mat.vz, mat.h22);
		end
	end

	// Accumulate each row with the rounding offset, then drop the fraction
	assign sum_x = qvr_pkg::AW'(p00_s3) + qvr_pkg::AW'(p01_s3) + qvr_pkg::AW'(p02_s3)
		+ qvr_pkg::RND;
	assign sum_y = qvr_pkg::AW'(p10_s3) + qvr_pkg::AW'(p11_s3) + qvr_pkg::AW'(p12_s3)
		+ qvr_pkg::RND;
	assign sum_z = qvr_pkg::AW'(p20_s3) + qvr_pkg::AW'(p21_s3) + qvr_pkg::AW'(p22_s3)
		+ qvr_pkg::RND;

	// Stage 4: hold the rounded sums
	always_ff @(posedge clk) begin
		if (valid_s3 && free_s4) begin
			rx_s4 <= sum_x[qvr_pkg::AW-1:qvr_pkg::FRAC_H];
			ry_s4 <= sum_y[qvr_pkg::AW-1:qvr_pkg::FRAC_H];
			rz_s4 <= sum_z[qvr_pkg::AW-1:qvr_pkg::FRAC_H];
		end
	end

	assign {ox, cx} = clamp(rx_s4);
	assign {oy, cy} = clamp(ry_s4);
	assign {oz, cz} = clamp(rz_s4);

	// Stage 5: saturated result register
	always_ff @(posedge clk) begin
		if (valid_s4 && free_s5) begin
			x_s5   <= cx;
			y_s5   <= cy;
			z_s5   <= cz;
			ovf_s5 <= ox || oy || oz;
		end
	end

	assign result.valid    = valid_s5;
	assign result.out_x    = x_s5;
	assign result.out_y    = y_s5;
	assign result.out_z    = z_s5;
	assign result.overflow = ovf_s5;

	// A flagged result has at least one component pinned at a bound
	`QVR_ASSERT_NOW(a_ovf_at_bound, clk, arst_n, valid_s5 && ovf_s5, (x_s5 == qvr_pkg::VEC_MAX) || (x_s5 == qvr_pkg::VEC_MIN) || (y_s5 == qvr_pkg::VEC_MAX) || (y_s5 == qvr_pkg::VEC_MIN) || (z_s5 == qvr_pkg::VEC_MAX) || (z_s5 == qvr_pkg::VEC_MIN), "overflow set with no component saturated")

	// A blocked output stage freezes the stage behind it
	`QVR_ASSERT_NEXT(a_s4_hold, clk, arst_n, valid_s4 && valid_s5 && !result.ready, valid_s4 && $stable(rx_s4) && $stable(ry_s4) && $stable(rz_s4), "stage 4 lost or changed a held transaction")

	// A stage 4 transaction with room ahead reaches the output register
	`QVR_ASSERT_NEXT(a_s4_advance, clk, arst_n, valid_s4 && free_s5, valid_s5, "stage 4 transaction dropped on advance")

endmodule

### rtl/core/quaternion_vector_rotate_top.sv
// Top level: rotates a 3-vector by a Q1.14 quaternion through a five-stage pipeline.
// Throughput: one transaction per cycle while the output is not stalled; every stage is registered.
// Each stage holds its transaction while the output is stalled; bubbles let input continue.
// Reset (arst_n low, asynchronous) clears all stage valid bits; no data is kept.
module quaternion_vector_rotate_top (
	input  logic      clk,
	input  logic      arst_n,
	qvr_in_if.sink    sample,
	qvr_out_if.source result
);

	logic              mat_valid;
	logic              mat_ready;
	qvr_pkg::qvr_mat_t mat;

	// Products and half matrix
	qvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat)
	);

	// Multiply-accumulate, round and saturate
	qvr_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_valid (mat_valid),
		.mat_ready (mat_ready),
		.mat       (mat),
		.result    (result)
	);

endmodule

### bench/qvr_check_pkg.sv
// Transaction types and the rotation scoreboard used by the quaternion rotation bench.
`timescale 1ns / 100ps
package qvr_check_pkg;
	import qvr_pkg::*;

	// Fraction bits of the accumulated sums (Q1.14 times Q1.14 times two)
	localparam int SUM_FRAC = 28;
	// Cap on printed mismatch lines; the count keeps going
	localparam int MAX_PRINT = 30;

	typedef struct packed {
		logic signed [QW-1:0] w;
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic signed [VW-1:0] vz;
	} rot_in_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] z;
		logic                 ovf;
	} rot_out_t;

	class rotation_scoreboard;
		rot_out_t    rotated_q[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned saturated;

		// Round half up to the vector scale, then clamp and flag
		function logic signed [VW-1:0] round_sat(longint acc, inout bit ovf);
			longint q;
			q = (acc + (longint'(1) << (SUM_FRAC - 1))) >>> SUM_FRAC;
			if (q > longint'(VEC_MAX)) begin
				q = longint'(VEC_MAX);
				ovf = 1'b1;
			end else if (q < longint'(VEC_MIN)) begin
				q = longint'(VEC_MIN);
				ovf = 1'b1;
			end
			return q[VW-1:0];
		endfunction

		// Apply the unnormalized rotation matrix of the quaternion to the vector
		function rot_out_t rotate(rot_in_t s);
			longint w, x, y, z, vx, vy, vz, unit;
			longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
			bit ovf;
			rot_out_t r;
			w = longint'(s.w);
			x = longint'(s.x);
			y = longint'(s.y);
			z = longint'(s.z);
			vx = longint'(s.vx);
			vy = longint'(s.vy);
			vz = longint'(s.vz);
			unit = longint'(1) << SUM_FRAC;
			m00 = 2 * (x * x + w * w) - unit;
			m01 = 2 * (x * y - w * z);
			m02 = 2 * (w * y + x * z);
			m10 = 2 * (x * y + w * z);
			m11 = 2 * (y * y + w * w) - unit;
			m12 = 2 * (y * z - w * x);
			m20 = 2 * (x * z - w * y);
			m21 = 2 * (w * x + y * z);
			m22 = 2 * (z * z + w * w) - unit;
			ovf = 1'b0;
			r.x = round_sat(vx * m00 + vy * m01 + vz * m02, ovf);
			r.y = round_sat(vx * m10 + vy * m11 + vz * m12, ovf);
			r.z = round_sat(vx * m20 + vy * m21 + vz * m22, ovf);
			r.ovf = ovf;
			return r;
		endfunction

		function void note_input(rot_in_t s);
			rotated_q.push_back(rotate(s));
		endfunction

		function int pending();
			return rotated_q.size();
		endfunction

		task report(string msg);
			if (mismatches < MAX_PRINT)
				$display("ERROR: result %0d: %s", checked, msg);
			mismatches++;
		endtask

		// Compare one output transaction with the oldest prediction
		task check_result(rot_out_t got);
			rot_out_t want;
			if (rotated_q.size() == 0) begin
				report($sformatf("unexpected output (%0d, %0d, %0d) overflow %0b",
					got.x, got.y, got.z, got.ovf));
				return;
			end
			want = rotated_q.pop_front();
			if (got.x !== want.x)
				report($sformatf("out_x %0d, expected %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("out_y %0d, expected %0d", got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("out_z %0d, expected %0d", got.z, want.z));
			if (got.ovf !== want.ovf)
				report($sformatf("overflow %0b, expected %0b", got.ovf, want.ovf));
			if (want.ovf)
				saturated++;
			checked++;
		endtask
	endclass

endpackage

### bench/tb.sv
// Top-level bench: drives quaternion/vector transactions and checks rotated results.
`timescale 1ns / 100ps
module tb;
	import qvr_pkg::*;
	import qvr_check_pkg::*;

	localparam int LATENCY     = 5;
	localparam int N_RANDOM    = 1630;
	localparam int HOLD_AT     = 500;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 2000;

	logic clk = 1'b0;
	logic arst_n;

	qvr_in_if  sample_bus ();
	qvr_out_if result_bus ();

	quaternion_vector_rotate_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_bus),
		.result (result_bus)
	);

	rotation_scoreboard sb = new();

	int unsigned n_in;
	int unsigned n_out;
	int unsigned n_drains;
	int unsigned n_directed;
	bit          rx_hold;
	bit          hold_done;

	always #2 clk = ~clk;

	// Gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Quaternion codes at the edges and at common rotations
	function automatic logic signed [QW-1:0] edge_code();
		case ($urandom_range(0, 8))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return -16'sd16384;
			3: return 16'sd16384;
			4: return 16'sd0;
			5: return 16'sd1;
			6: return -16'sd1;
			7: return 16'sd11585;
			default: return -16'sd11585;
		endcase
	endfunction

	// Vector component: full range, small, medium or an extreme
	function automatic logic signed [VW-1:0] pick_vec();
		int unsigned r;
		logic signed [VW-1:0] v;
		r = $urandom_range(0, 99);
		if (r < 40)
			v = VW'($urandom);
		else if (r < 70)
			v = VW'(int'($urandom_range(0, 2000)) - 1000);
		else if (r < 85)
			v = VW'(int'($urandom_range(0, 2 ** 21 - 1)) - 2 ** 20);
		else begin
			case ($urandom_range(0, 4))
				0: v = VEC_MIN;
				1: v = VEC_MAX;
				2: v = '0;
				3: v = '1;
				default: v = VW'(1);
			endcase
		end
		return v;
	endfunction

	function automatic rot_in_t mk(int w, int x, int y, int z, int vx, int vy, int vz);
		rot_in_t s;
		s.w = QW'(w);
		s.x = QW'(x);
		s.y = QW'(y);
		s.z = QW'(z);
		s.vx = VW'(vx);
		s.vy = VW'(vy);
		s.vz = VW'(vz);
		return s;
	endfunction

	// Offer one transaction after an optional gap and hold it until accepted
	task automatic send(rot_in_t s, int unsigned gap);
		if (gap != 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.quat_w <= s.w;
		sample_bus.quat_x <= s.x;
		sample_bus.quat_y <= s.y;
		sample_bus.quat_z <= s.z;
		sample_bus.vec_x <= s.vx;
		sample_bus.vec_y <= s.vy;
		sample_bus.vec_z <= s.vz;
		@(posedge clk);
		while (!sample_bus.ready) @(posedge clk);
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic drain();
		sample_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		n_drains++;
	endtask

	// Record accepted inputs and check accepted outputs
	always @(posedge clk) begin : monitor
		rot_in_t  s;
		rot_out_t r;
		if (arst_n) begin
			if (sample_bus.valid && sample_bus.ready) begin
				s.w = sample_bus.quat_w;
				s.x = sample_bus.quat_x;
				s.y = sample_bus.quat_y;
				s.z = sample_bus.quat_z;
				s.vx = sample_bus.vec_x;
				s.vy = sample_bus.vec_y;
				s.vz = sample_bus.vec_z;
				sb.note_input(s);
				n_in++;
			end
			if (result_bus.valid && result_bus.ready) begin
				r.x = result_bus.out_x;
				r.y = result_bus.out_y;
				r.z = result_bus.out_z;
				r.ovf = result_bus.overflow;
				sb.check_result(r);
				n_out++;
			end
		end
	end

	// Stall the output at random; hold it off once for a long stretch
	initial begin : receiver
		int unsigned stall;
		result_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!hold_done && n_in >= HOLD_AT) begin
				rx_hold = 1'b1;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 1'b0;
				hold_done = 1'b1;
			end
			stall = pick_gap();
			if (stall != 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 6)) @(posedge clk);
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int unsigned idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((sample_bus.valid && sample_bus.ready) ||
				(result_bus.valid && result_bus.ready))
				idle = 0;
			else
				idle++;
		end
		$display("ERROR: no transaction for %0d cycles, %0d results outstanding",
			IDLE_LIMIT, sb.pending());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		rot_in_t directed[$];
		rot_in_t s;
		real a, b, c, d, n;
		int unsigned r;
		int unsigned gap;

		arst_n <= 1'b0;
		sample_bus.valid <= 1'b0;
		sample_bus.quat_w <= '0;
		sample_bus.quat_x <= '0;
		sample_bus.quat_y <= '0;
		sample_bus.quat_z <= '0;
		sample_bus.vec_x <= '0;
		sample_bus.vec_y <= '0;
		sample_bus.vec_z <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity, quarter and half turns, zero and extreme quaternions, rounding ties
		directed.push_back(mk(16384, 0, 0, 0, 1, 2, 3));
		directed.push_back(mk(16384, 0, 0, 0, 8388607, -8388608, 0));
		directed.push_back(mk(-16384, 0, 0, 0, 12345, -6789, 4242));
		directed.push_back(mk(11585, 0, 0, 11585, 1000, 0, 0));
		directed.push_back(mk(11585, 11585, 0, 0, 0, 1000, -1000));
		directed.push_back(mk(11585, 0, 11585, 0, -5000, 7, 5000));
		directed.push_back(mk(0, 16384, 0, 0, -8388608, -8388608, -8388608));
		directed.push_back(mk(0, 16384, 0, 0, 8388607, 8388607, 8388607));
		directed.push_back(mk(8192, 8192, 8192, 8192, 8388607, -8388608, 1));
		directed.push_back(mk(0, 0, 0, 0, -8388608, 1, -1));
		directed.push_back(mk(0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607));
		directed.push_back(mk(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608));
		directed.push_back(mk(-32768, 0, 0, 0, 1, 1, 1));
		directed.push_back(mk(0, -32768, 32767, 0, -1, -1, -1));
		directed.push_back(mk(0, 0, 32767, -32768, 8388607, 0, -8388608));
		directed.push_back(mk(8192, 0, 0, 0, 1, -1, 3));
		directed.push_back(mk(-8192, 0, 0, 0, -3, 5, -5));
		directed.push_back(mk(4096, 4096, -4096, 0, 7, -9, 11));
		directed.push_back(mk(32767, -32768, 1, -1, 0, 8388607, -8388608));
		foreach (directed[i])
			send(directed[i], rx_hold ? 0 : pick_gap());
		n_directed = directed.size();
		drain();

		for (int i = 0; i < N_RANDOM; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				// Unit quaternion, occasionally nudged off unit length
				a = int'($urandom_range(0, 65534)) - 32767;
				b = int'($urandom_range(0, 65534)) - 32767;
				c = int'($urandom_range(0, 65534)) - 32767;
				d = int'($urandom_range(0, 65534)) - 32767;
				n = $sqrt(a * a + b * b + c * c + d * d);
				if (n < 1.0) begin
					a = 1.0;
					n = 1.0;
				end
				s.w = QW'(int'(a * 16384.0 / n));
				s.x = QW'(int'(b * 16384.0 / n));
				s.y = QW'(int'(c * 16384.0 / n));
				s.z = QW'(int'(d * 16384.0 / n));
				if ($urandom_range(0, 3) == 0)
					s.w = QW'(int'(s.w) + int'($urandom_range(0, 6)) - 3);
			end else if (r < 75) begin
				// Arbitrary codes in every field
				s.w = QW'($urandom);
				s.x = QW'($urandom);
				s.y = QW'($urandom);
				s.z = QW'($urandom);
			end else if (r < 90) begin
				s.w = edge_code();
				s.x = edge_code();
				s.y = edge_code();
				s.z = edge_code();
			end else begin
				// Coarse components give matrix entries that land on rounding ties
				s.w = QW'((int'($urandom_range(0, 8)) - 4) * 4096);
				s.x = QW'((int'($urandom_range(0, 8)) - 4) * 4096);
				s.y = QW'((int'($urandom_range(0, 8)) - 4) * 4096);
				s.z = QW'((int'($urandom_range(0, 8)) - 4) * 4096);
			end
			if (r >= 55 && r < 75) begin
				s.vx = VW'($urandom);
				s.vy = VW'($urandom);
				s.vz = VW'($urandom);
			end else if (r >= 90) begin
				s.vx = VW'(int'($urandom_range(0, 64)) - 32);
				s.vy = VW'(int'($urandom_range(0, 64)) - 32);
				s.vz = VW'(int'($urandom_range(0, 64)) - 32);
			end else begin
				s.vx = pick_vec();
				s.vy = pick_vec();
				s.vz = pick_vec();
			end
			// Keep offering while the output is held off; run back to back in bursts
			if (rx_hold || (i % 150) < 40)
				gap = 0;
			else
				gap = pick_gap();
			send(s, gap);
			if (i == 400 || i == 1100)
				drain();
		end
		sample_bus.valid <= 1'b0;

		// Let outstanding results arrive, then watch for stray outputs
		while (sb.pending() != 0) @(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);

		$display("Covered %0d input transactions (%0d directed) and %0d output transactions,",
			n_in, n_directed, n_out);
		$display("%0d of them saturated; output held off %0d cycles once, input drained %0d times.",
			sb.saturated, HOLD_CYCLES, n_drains);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
